/* rtl/csc_pkg.sv */
`default_nettype none

package csc_pkg;

    localparam int VAL_W       = 56;
    localparam int CFG_W       = 55;
    localparam int RED_W       = 25;
    localparam int AGGR_W      = 29;
    localparam int MAXIT_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int OPND_W      = 64;
    localparam int PROD_W      = 2 * OPND_W;

    localparam int FRAC_BITS_DEF = 24;
    localparam int ITER_BITS_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STEP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AGGR       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXIT      = 3'd5;

    localparam logic [VAL_W-1:0] SMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SMIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef logic signed [VAL_W-1:0] val_t;

    // magnitude of a signed value; the most negative value maps to 2^55
    function automatic logic [VAL_W-1:0] mag_of(input logic [VAL_W-1:0] x);
        mag_of = x[VAL_W-1] ? (~x + 1'b1) : x;
    endfunction

    // negate with saturation of the most negative value
    function automatic logic [VAL_W-1:0] neg_sat(input logic [VAL_W-1:0] x);
        neg_sat = (x == SMIN) ? SMAX : (~x + 1'b1);
    endfunction

    // rebuild a signed value from sign and magnitude, saturating on overflow
    function automatic logic [VAL_W-1:0] make_val(input logic neg, input logic ovf,
                                                  input logic [VAL_W-2:0] m);
        logic [VAL_W-1:0] pos;
        pos = {1'b0, m};
        if (ovf)
            make_val = neg ? SMIN : SMAX;
        else
            make_val = neg ? (~pos + 1'b1) : pos;
    endfunction

endpackage

`default_nettype wire

/* rtl/csc_mul.sv */
`default_nettype none

module csc_mul (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [csc_pkg::OPND_W-1:0] a,
    input  wire logic [csc_pkg::OPND_W-1:0] b,
    output logic                            done,
    output logic [csc_pkg::PROD_W-1:0]      prod
);
    import csc_pkg::*;

    localparam int HALF_W = OPND_W / 2;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [2:0]            cnt_reg, cnt_next;
    logic [1:0]            sh_reg;
    logic [OPND_W-1:0]     a_reg, b_reg;
    logic [OPND_W-1:0]     pp_reg;
    logic [PROD_W-1:0]     acc_reg, acc_next;
    logic [HALF_W-1:0]     a_sel, b_sel;
    logic [PROD_W-1:0]     pp_shift;

    assign a_sel = cnt_reg[1] ? a_reg[OPND_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_sel = cnt_reg[0] ? b_reg[OPND_W-1:HALF_W] : b_reg[HALF_W-1:0];

    always_comb
    begin
        case (sh_reg)
            2'd0:    pp_shift = {{OPND_W{1'b0}}, pp_reg};
            2'd1:    pp_shift = {{HALF_W{1'b0}}, pp_reg, {HALF_W{1'b0}}};
            default: pp_shift = {pp_reg, {OPND_W{1'b0}}};
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 3'd0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != 3'd0)
                acc_next = acc_reg + pp_shift;
            cnt_next = cnt_reg + 3'd1;
            if (cnt_reg == 3'd4)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        // one partial product per cycle, added in the next
        pp_reg <= OPND_W'(a_sel) * OPND_W'(b_sel);
        sh_reg <= 2'({1'b0, cnt_reg[1]} + {1'b0, cnt_reg[0]});
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

/* rtl/csc_div.sv */
`default_nettype none

module csc_div #(
    parameter int DW = 80
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [DW-1:0]             dividend,
    input  wire logic [csc_pkg::VAL_W-1:0] divisor,
    output logic                           done,
    output logic [DW-1:0]                  quot
);
    import csc_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CW-1:0]       cnt_reg;
    logic [VAL_W-1:0]    rem_reg;
    logic [VAL_W-1:0]    dvs_reg;
    logic [DW-1:0]       q_reg;
    logic [VAL_W:0]      trial;
    logic                fits;

    assign trial = {rem_reg, q_reg[DW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? VAL_W'(trial - {1'b0, dvs_reg}) : VAL_W'(trial);
            q_reg   <= {q_reg[DW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

`default_nettype wire

/* rtl/continuation_step_size_control.sv */
// Adaptive step-size controller, signed Q32.24 (FRAC_BITS fraction bits).
// Input channel: in_valid / in_stall with solve_ok, slope, scale_ratio,
// iterations and current_step; a request is taken when in_valid is high and
// in_stall low. One result per request on out_valid / out_stall: new_step,
// hit_minimum, previous_step and scaled_start.
// Configuration: cfg_we, cfg_index, cfg_wdata; to be written by the user while
// idle, which the block does not enforce; the first request after reset
// copies max, min and start step into the working state. One request is
// processed at a time by a sequencer around a shared 32x32-partial-product
// multiplier (64x64 product steps) and a restoring divider. A first request
// divides start, max and min step by the slope, or skips this for a zero
// slope; a failed solve scales the step by the reduction factor; a
// successful solve scales start, max, min and step, and skips the
// aggressiveness growth term for a zero iteration limit. All paths end
// by clipping the step magnitude between min and max.
// in_stall is high while a request is in work. The result sits in an output
// register; a new request can be taken while it waits, and the sequencer
// holds at the end until out_stall lets the previous result go.
// Reset clears the sequencer and output valid and restores register defaults.
`default_nettype none

module continuation_step_size_control #(
    parameter int FRAC_BITS = csc_pkg::FRAC_BITS_DEF,
    parameter int ITER_BITS = csc_pkg::ITER_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [csc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [csc_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          solve_ok,
    input  wire logic signed [csc_pkg::VAL_W-1:0] slope,
    input  wire logic signed [csc_pkg::VAL_W-1:0] scale_ratio,
    input  wire logic [ITER_BITS-1:0]          iterations,
    input  wire logic signed [csc_pkg::VAL_W-1:0] current_step,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic signed [csc_pkg::VAL_W-1:0]   new_step,
    output logic                               hit_minimum,
    output logic signed [csc_pkg::VAL_W-1:0]   previous_step,
    output logic signed [csc_pkg::VAL_W-1:0]   scaled_start
);
    import csc_pkg::*;

    localparam int DW    = VAL_W + FRAC_BITS;
    localparam int RED_RW = (FRAC_BITS + 1 > RED_W) ? FRAC_BITS + 1 : RED_W;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DIV_ST  = 5'd1;
    localparam logic [4:0] S_DIV_HI  = 5'd2;
    localparam logic [4:0] S_DIV_LO  = 5'd3;
    localparam logic [4:0] S_MUL_RED = 5'd4;
    localparam logic [4:0] S_MUL_ST  = 5'd5;
    localparam logic [4:0] S_MUL_HI  = 5'd6;
    localparam logic [4:0] S_MUL_LO  = 5'd7;
    localparam logic [4:0] S_MUL_DD  = 5'd8;
    localparam logic [4:0] S_MUL_MM  = 5'd9;
    localparam logic [4:0] S_MUL_AG  = 5'd10;
    localparam logic [4:0] S_DIV_G   = 5'd11;
    localparam logic [4:0] S_MUL_G   = 5'd12;
    localparam logic [4:0] S_MUL_RAT = 5'd13;
    localparam logic [4:0] S_CLIP_HI = 5'd14;
    localparam logic [4:0] S_CLIP_LO = 5'd15;
    localparam logic [4:0] S_DONE    = 5'd16;

    // configuration registers
    logic [CFG_W-1:0]   max_reg, min_reg, start_cfg_reg;
    logic [RED_RW-1:0]  red_reg;
    logic [AGGR_W-1:0]  aggr_reg;
    logic [MAXIT_W-1:0] maxit_reg;

    // working state
    logic [4:0]          state_reg;
    logic                go_reg;
    logic                first_reg;
    logic                neg_reg;
    logic                hit_reg;
    logic [VAL_W-1:0]    slope_reg, ratio_reg, step_reg;
    logic [VAL_W-1:0]    hi_reg, lo_reg, start_reg, prev_reg;
    logic [ITER_BITS-1:0] iters_reg;
    logic [OPND_W-1:0]   t1_reg, t2_reg;

    logic                out_valid_reg;
    logic [VAL_W-1:0]    out_step_reg, out_prev_reg, out_start_reg;
    logic                out_hit_reg;

    // shared units
    logic                is_mul, is_div;
    logic                mul_start, mul_done, mul_neg;
    logic [OPND_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0]   mul_prod, mul_shift;
    logic [VAL_W-1:0]    mul_q;
    logic                div_start, div_done;
    logic [DW-1:0]       div_dvd, div_quot;
    logic [VAL_W-1:0]    div_dvs, div_q;

    logic [ITER_BITS-1:0] mx, dd;
    logic [VAL_W-1:0]    step_mag;
    logic                gt_hi, lt_lo;
    logic                accept, out_free;

    assign accept   = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign out_free = !out_valid_reg || !out_stall;

    assign mx = ITER_BITS'(maxit_reg);
    assign dd = (mx >= iters_reg) ? (mx - iters_reg) : (iters_reg - mx);

    assign step_mag = mag_of(step_reg);
    assign gt_hi = $signed({1'b0, step_mag}) > $signed({hi_reg[VAL_W-1], hi_reg});
    assign lt_lo = $signed({1'b0, step_mag}) < $signed({lo_reg[VAL_W-1], lo_reg});

    always_comb
    begin
        is_mul  = 1'b1;
        mul_a   = {{(OPND_W-VAL_W){1'b0}}, step_mag};
        mul_b   = {{(OPND_W-VAL_W){1'b0}}, mag_of(ratio_reg)};
        mul_neg = step_reg[VAL_W-1] ^ ratio_reg[VAL_W-1];
        case (state_reg)
            S_MUL_RED:
            begin
                mul_b   = OPND_W'(red_reg);
                mul_neg = step_reg[VAL_W-1];
            end
            S_MUL_ST:
            begin
                mul_a   = {{(OPND_W-VAL_W){1'b0}}, mag_of(start_reg)};
                mul_neg = start_reg[VAL_W-1] ^ ratio_reg[VAL_W-1];
            end
            S_MUL_HI:
            begin
                mul_a   = {{(OPND_W-VAL_W){1'b0}}, mag_of(hi_reg)};
                mul_neg = hi_reg[VAL_W-1] ^ ratio_reg[VAL_W-1];
            end
            S_MUL_LO:
            begin
                mul_a   = {{(OPND_W-VAL_W){1'b0}}, mag_of(lo_reg)};
                mul_neg = lo_reg[VAL_W-1] ^ ratio_reg[VAL_W-1];
            end
            S_MUL_DD:
            begin
                mul_a = OPND_W'(dd);
                mul_b = OPND_W'(dd);
            end
            S_MUL_MM:
            begin
                mul_a = OPND_W'(mx);
                mul_b = OPND_W'(mx);
            end
            S_MUL_AG:
            begin
                mul_a = OPND_W'(aggr_reg);
                mul_b = t1_reg;
            end
            S_MUL_G:
            begin
                mul_b   = t1_reg;
                mul_neg = step_reg[VAL_W-1];
            end
            S_MUL_RAT: ;
            default: is_mul = 1'b0;
        endcase
    end

    always_comb
    begin
        is_div  = 1'b1;
        div_dvs = mag_of(slope_reg);
        div_dvd = {mag_of(start_reg), {FRAC_BITS{1'b0}}};
        case (state_reg)
            S_DIV_ST: ;
            S_DIV_HI: div_dvd = {mag_of(hi_reg), {FRAC_BITS{1'b0}}};
            S_DIV_LO: div_dvd = {mag_of(lo_reg), {FRAC_BITS{1'b0}}};
            S_DIV_G:
            begin
                div_dvd = DW'(t1_reg);
                div_dvs = t2_reg[VAL_W-1:0];
            end
            default: is_div = 1'b0;
        endcase
    end

    assign mul_start = is_mul && !go_reg;
    assign div_start = is_div && !go_reg;

    assign mul_shift = mul_prod >> FRAC_BITS;
    assign mul_q = make_val(mul_neg, |mul_shift[PROD_W-1:VAL_W-1], mul_shift[VAL_W-2:0]);
    assign div_q = make_val(slope_reg[VAL_W-1], |div_quot[DW-1:VAL_W-1],
                            div_quot[VAL_W-2:0]);

    csc_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    csc_div #(
        .DW (DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quot     (div_quot)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= {CFG_W{1'b1}};
            min_reg       <= CFG_W'(1);
            start_cfg_reg <= CFG_W'(1) << FRAC_BITS;
            red_reg       <= RED_RW'(1) << (FRAC_BITS - 1);
            aggr_reg      <= '0;
            maxit_reg     <= MAXIT_W'(15);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_STEP:   max_reg       <= cfg_wdata;
                CFG_MIN_STEP:   min_reg       <= cfg_wdata;
                CFG_START_STEP: start_cfg_reg <= cfg_wdata;
                CFG_REDUCE:     red_reg       <= RED_RW'(cfg_wdata[RED_W-1:0]);
                CFG_AGGR:       aggr_reg      <= cfg_wdata[AGGR_W-1:0];
                CFG_MAXIT:      maxit_reg     <= cfg_wdata[MAXIT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            go_reg        <= 1'b0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
            hi_reg        <= {1'b0, {CFG_W{1'b1}}};
            lo_reg        <= VAL_W'(1);
            start_reg     <= VAL_W'(1) << FRAC_BITS;
            prev_reg      <= '0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (mul_start || div_start)
                go_reg <= 1'b1;
            if (mul_done || div_done)
                go_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (first_reg)
                        begin
                            first_reg <= 1'b0;
                            hi_reg    <= {1'b0, max_reg};
                            lo_reg    <= {1'b0, min_reg};
                            start_reg <= {1'b0, start_cfg_reg};
                            prev_reg  <= '0;
                            if (slope == '0)
                                state_reg <= S_CLIP_HI;
                            else
                                state_reg <= S_DIV_ST;
                        end
                        else if (!solve_ok)
                            state_reg <= S_MUL_RED;
                        else
                        begin
                            prev_reg  <= current_step;
                            state_reg <= S_MUL_ST;
                        end
                    end
                end
                S_DIV_ST:
                    if (div_done)
                    begin
                        start_reg <= div_q;
                        state_reg <= S_DIV_HI;
                    end
                S_DIV_HI:
                    if (div_done)
                    begin
                        hi_reg    <= div_q;
                        state_reg <= S_DIV_LO;
                    end
                S_DIV_LO:
                    if (div_done)
                    begin
                        lo_reg    <= div_q;
                        state_reg <= S_CLIP_HI;
                    end
                S_MUL_RED:
                    if (mul_done)
                        state_reg <= S_CLIP_HI;
                S_MUL_ST:
                    if (mul_done)
                    begin
                        start_reg <= mul_q;
                        state_reg <= S_MUL_HI;
                    end
                S_MUL_HI:
                    if (mul_done)
                    begin
                        hi_reg    <= mul_q;
                        state_reg <= S_MUL_LO;
                    end
                S_MUL_LO:
                    if (mul_done)
                    begin
                        lo_reg    <= mul_q;
                        state_reg <= (mx != '0) ? S_MUL_DD : S_MUL_G;
                    end
                S_MUL_DD:
                    if (mul_done)
                        state_reg <= S_MUL_MM;
                S_MUL_MM:
                    if (mul_done)
                        state_reg <= S_MUL_AG;
                S_MUL_AG:
                    if (mul_done)
                        state_reg <= S_DIV_G;
                S_DIV_G:
                    if (div_done)
                        state_reg <= S_MUL_G;
                S_MUL_G:
                    if (mul_done)
                        state_reg <= S_MUL_RAT;
                S_MUL_RAT:
                    if (mul_done)
                        state_reg <= S_CLIP_HI;
                S_CLIP_HI:
                    state_reg <= S_CLIP_LO;
                S_CLIP_LO:
                    state_reg <= S_DONE;
                S_DONE:
                    // hold until the previous result has been taken
                    if (out_free)
                        state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers without reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slope_reg <= slope;
            ratio_reg <= scale_ratio;
            iters_reg <= iterations;
            step_reg  <= first_reg ? {1'b0, start_cfg_reg} : current_step;
        end

        case (state_reg)
            S_DIV_LO:
                if (div_done)
                    step_reg <= start_reg;
            S_MUL_RED, S_MUL_G, S_MUL_RAT:
                if (mul_done)
                    step_reg <= mul_q;
            S_MUL_LO:
                if (mul_done)
                    t1_reg <= OPND_W'(1) << FRAC_BITS;
            S_MUL_DD, S_MUL_AG:
                if (mul_done)
                    t1_reg <= mul_prod[OPND_W-1:0];
            S_MUL_MM:
                if (mul_done)
                    t2_reg <= mul_prod[OPND_W-1:0];
            S_DIV_G:
                if (div_done)
                    t1_reg <= (OPND_W'(1) << FRAC_BITS) + div_quot[OPND_W-1:0];
            S_CLIP_HI:
            begin
                neg_reg <= step_reg[VAL_W-1];
                if (gt_hi)
                    step_reg <= step_reg[VAL_W-1] ? neg_sat(hi_reg) : hi_reg;
            end
            S_CLIP_LO:
            begin
                hit_reg <= lt_lo;
                if (lt_lo)
                    step_reg <= neg_reg ? neg_sat(lo_reg) : lo_reg;
            end
            default: ;
        endcase

        if (state_reg == S_DONE && out_free)
        begin
            out_step_reg  <= step_reg;
            out_hit_reg   <= hit_reg;
            out_prev_reg  <= prev_reg;
            out_start_reg <= start_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign new_step      = out_step_reg;
    assign hit_minimum   = out_hit_reg;
    assign previous_step = out_prev_reg;
    assign scaled_start  = out_start_reg;

`ifndef ASSERT_OFF
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> in_stall)
        else $error("request accepted but sequencer not busy");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside final state");

    a_idle_no_go: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !go_reg)
        else $error("unit still running while idle");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(mul_start && div_start))
        else $error("multiplier and divider started together");
`endif

endmodule

`default_nettype wire
